// ----- hdl/firmac_pkg.sv -----
package firmac_pkg;

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic use_tap;
        logic round;
    } mac_ctrl_t;

endpackage

// ----- hdl/firmac_mac_unit.sv -----
module firmac_mac_unit
    import firmac_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int ACC_W       = 44
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctrl_t                     ctrl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          busy,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          saturated
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;

    logic signed [PW-1:0]    prod_reg;
    logic                    prod_valid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] smax;
    logic signed [ACC_W-1:0] smin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.use_tap)
        begin
            prod_reg <= coef * sample;
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    always_comb
    begin
        if (ctrl.round)
        begin
            addend = ACC_W'(1) <<< (COEF_BITS - 2);
        end
        else
        begin
            addend = ACC_W'(prod_reg);
        end
        sum = {addend[ACC_W-1], addend} + {acc_reg[ACC_W-1], acc_reg};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg || ctrl.round)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        smax    = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        smin    = ~smax;
        shifted = acc_reg >>> (COEF_BITS - 1);
        if (shifted > smax)
        begin
            result    = smax[SAMPLE_BITS-1:0];
            saturated = 1'b1;
        end
        else if (shifted < smin)
        begin
            result    = smin[SAMPLE_BITS-1:0];
            saturated = 1'b1;
        end
        else
        begin
            result    = shifted[SAMPLE_BITS-1:0];
            saturated = 1'b0;
        end
    end

    assign busy = prod_valid_reg;

endmodule

// ----- hdl/fir_filter_mac_top.sv -----
// Direct-form FIR filter with one shared multiply-accumulate unit.
// Input words arrive on the s_axis channel; tuser carries the opcode (filter
// sample, load coefficient, clear history) and tdata carries sample_in,
// coef_index and coef_value. Only a filter word yields an output word on the
// m_axis channel: tdata holds the filtered sample and tuser the saturation flag.
// The tap count is written through cfg_we and cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce this.
// For a filter word the single multiplier handles one tap per cycle, followed by
// the draining of the read, product and accumulator registers, a rounding step
// and the output load. With a tap count of zero the sample is passed straight to
// the output load. Load, clear and unused opcodes finish in the cycle they are
// accepted. The block takes one word at a time and drops s_axis_tready while a
// filter word is in progress, until its result is in the output register.
// If the receiver stalls, the result is held in the output register; the block
// keeps taking words, but the next result waits until the register is free and
// no word is accepted meanwhile.
// Reset clears the history, the write pointer and the tap count; coefficients
// are undefined until loaded.
module fir_filter_mac_top
    import firmac_pkg::*;
#(
    parameter int MAX_TAPS    = 512,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    localparam int IN_W       = ((SAMPLE_BITS + 9 + COEF_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // sample_in, coef_index, coef_value (lowest bits first), zero padded
    input  logic [IN_W-1:0]     s_axis_tdata,
    // opcode
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // sample_out, zero padded
    output logic [OUT_W-1:0]    m_axis_tdata,
    // saturated
    output logic                m_axis_tuser
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int CW     = $clog2(MAX_TAPS + 1);
    localparam int ACC_RAW = SAMPLE_BITS + COEF_BITS + AW + 1;
    localparam int ACC_W  = (ACC_RAW > 64) ? 64 : ACC_RAW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_ROUND = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [8:0]              tap_count_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [AW-1:0]           rp_reg, rp_next;
    logic                    pass_reg, pass_next;
    logic [SAMPLE_BITS-1:0]  pass_data_reg, pass_data_next;
    logic                    rd_valid_reg;
    logic                    rd_use_reg;
    logic [COEF_BITS-1:0]    coef_rd_reg;
    logic [SAMPLE_BITS-1:0]  hist_rd_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_data_reg;
    logic                    out_sat_reg;

    logic [COEF_BITS-1:0]    coef_mem [MAX_TAPS];
    logic [SAMPLE_BITS-1:0]  hist_mem [MAX_TAPS];

    opcode_t                 opcode;
    logic [SAMPLE_BITS-1:0]  sample_in;
    logic [8:0]              coef_index;
    logic [COEF_BITS-1:0]    coef_value;
    logic                    in_fire;
    logic                    out_load;
    logic [31:0]             tc32;
    logic [CW-1:0]           taps_eff;
    logic [AW-1:0]           wp_inc;
    logic                    hist_we;
    logic                    coef_we;
    logic                    issue;
    mac_ctrl_t               mac_ctrl;
    logic                    mac_busy;
    logic [SAMPLE_BITS-1:0]  mac_result;
    logic                    mac_sat;

    assign opcode     = opcode_t'(s_axis_tuser);
    assign sample_in  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign coef_index = s_axis_tdata[SAMPLE_BITS+8:SAMPLE_BITS];
    assign coef_value = s_axis_tdata[SAMPLE_BITS+9+COEF_BITS-1:SAMPLE_BITS+9];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign issue         = (state_reg == S_RUN);

    assign tc32     = 32'(tap_count_reg);
    assign taps_eff = (tc32 > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tc32);
    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign hist_we  = in_fire && (opcode == OP_FILTER) && (taps_eff != '0);
    assign coef_we  = in_fire && (opcode == OP_LOAD) && (32'(coef_index) < 32'(MAX_TAPS));

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        pass_next      = pass_reg;
        pass_data_next = pass_data_reg;
        mac_ctrl       = '0;
        mac_ctrl.valid   = rd_valid_reg;
        mac_ctrl.use_tap = rd_use_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        OP_FILTER:
                        begin
                            if (taps_eff == '0)
                            begin
                                pass_next      = 1'b1;
                                pass_data_next = sample_in;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                pass_next      = 1'b0;
                                wp_next        = wp_inc;
                                rp_next        = wp_inc;
                                cnt_next       = '0;
                                mac_ctrl.clear = 1'b1;
                                if (fill_reg != CW'(MAX_TAPS))
                                begin
                                    fill_next = fill_reg + 1'b1;
                                end
                                state_next = S_RUN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next   = '0;
                            fill_next = '0;
                        end
                        OP_LOAD, OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                rp_next  = (rp_reg == '0) ? AW'(MAX_TAPS - 1) : rp_reg - 1'b1;
                if (cnt_reg == taps_eff - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                mac_ctrl.round = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_count_reg <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            pass_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            rp_reg       <= rp_next;
            pass_reg     <= pass_next;
            rd_valid_reg <= issue;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_data_reg <= pass_data_next;
        rd_use_reg    <= cnt_reg < fill_reg;
        if (out_load)
        begin
            out_data_reg <= pass_reg ? pass_data_reg : mac_result;
            out_sat_reg  <= pass_reg ? 1'b0 : mac_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[AW'(coef_index)] <= coef_value;
        end
        coef_rd_reg <= coef_mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_inc] <= sample_in;
        end
        hist_rd_reg <= hist_mem[rp_reg];
    end

    firmac_mac_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .coef      (coef_rd_reg),
        .sample    (hist_rd_reg),
        .busy      (mac_busy),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_sat_reg;

endmodule
